/* hw/rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Stack depth, bracket kinds, error codes and the transaction payloads.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int MAX_DEPTH = 256;
  localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  typedef enum logic [2:0] {
    ERR_NONE            = 3'd0,
    ERR_UNMATCHED_CLOSE = 3'd1,
    ERR_KIND_MISMATCH   = 3'd2,
    ERR_UNCLOSED_OPEN   = 3'd3,
    ERR_DEPTH_OVERFLOW  = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } bbc_in_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] error_code;
  } bbc_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  function automatic kind_t open_kind(input logic [7:0] b);
    kind_t k;
    k = KIND_NONE;
    if (b == CH_OPEN_ROUND)  k = KIND_ROUND;
    if (b == CH_OPEN_SQUARE) k = KIND_SQUARE;
    if (b == CH_OPEN_CURLY)  k = KIND_CURLY;
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] b);
    kind_t k;
    k = KIND_NONE;
    if (b == CH_CLOSE_ROUND)  k = KIND_ROUND;
    if (b == CH_CLOSE_SQUARE) k = KIND_SQUARE;
    if (b == CH_CLOSE_CURLY)  k = KIND_CURLY;
    return k;
  endfunction

endpackage

/* hw/rtl/bracket_balance_checker.sv */
// The result of a text is registered when its last byte is accepted. Throughput:
// one byte per cycle while in_stall is low; each byte is one push, one pop or
// neither on a row of MAX_DEPTH shifting cells whose top sits next to the control
// logic. A two-entry output stage keeps bytes flowing while a result waits.
// Reset clears stack level, first error and output valids; cells need no clearing.
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming balanced-bracket checker
// Tracks nesting on a cell-chain stack and reports one verdict per text.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bbc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bbc_out_t out_data
);

  logic [LEVEL_W-1:0] level_r, level_nxt;
  err_t               ferr_r, ferr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  bbc_out_t           out_data_r, out_data_nxt;
  bbc_out_t           skid_data_r, skid_data_nxt;

  kind_t     kind_w [MAX_DEPTH];
  stack_op_t op;
  kind_t     okind, ckind;
  err_t      ferr_upd, res_err;
  logic      in_acc, out_take;
  logic [LEVEL_W-1:0] level_upd;
  bbc_out_t  res;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign okind = open_kind(in_data.text_byte);
  assign ckind = close_kind(in_data.text_byte);

  // Stack update for the accepted byte; bytes after an error are dropped
  always_comb begin
    op        = '0;
    level_upd = level_r;
    ferr_upd  = ferr_r;
    if (in_acc && ferr_r == ERR_NONE) begin
      if (okind != KIND_NONE) begin
        if (level_r == LEVEL_W'(MAX_DEPTH)) begin
          ferr_upd = ERR_DEPTH_OVERFLOW;
        end else begin
          op.push   = 1'b1;
          level_upd = level_r + LEVEL_W'(1);
        end
      end else if (ckind != KIND_NONE) begin
        if (level_r == '0) begin
          ferr_upd = ERR_UNMATCHED_CLOSE;
        end else begin
          op.pop    = 1'b1;
          level_upd = level_r - LEVEL_W'(1);
          if (kind_w[0] != ckind) begin
            ferr_upd = ERR_KIND_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    res_err = ferr_upd;
    if (ferr_upd == ERR_NONE && level_upd != '0) begin
      res_err = ERR_UNCLOSED_OPEN;
    end
    res.balanced   = (res_err == ERR_NONE);
    res.error_code = res_err;
  end

  // Clear level and error after the last byte of a text
  always_comb begin
    level_nxt = level_upd;
    ferr_nxt  = ferr_upd;
    if (in_acc && in_data.end_of_text) begin
      level_nxt = '0;
      ferr_nxt  = ERR_NONE;
    end
  end

  // Output register plus skid slot
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc && in_data.end_of_text) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= '0;
      ferr_r       <= ERR_NONE;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      level_r      <= level_nxt;
      ferr_r       <= ferr_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Cell 0 is the stack top; a push shifts every entry one cell down
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    kind_t above, below;
    if (i == 0) begin : g_top
      assign above = okind;
    end else begin : g_mid
      assign above = kind_w[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_bot
      assign below = KIND_ROUND;
    end else begin : g_nbot
      assign below = kind_w[i+1];
    end
    bbc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .kind_above(above),
      .kind_below(below),
      .kind_q    (kind_w[i])
    );
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_W'(MAX_DEPTH))
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.end_of_text) |=> (level_r == '0 && ferr_r == ERR_NONE))
    else $error("state not cleared after last byte");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.balanced == (out_data_r.error_code == ERR_NONE)))
    else $error("balanced flag disagrees with error code");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.push && op.pop))
    else $error("push and pop in one cycle");

endmodule

/* hw/rtl/bbc_cell.sv */
// ----------------------------------------------------------------------------
// bbc_cell: one entry of the shifting bracket stack
// Takes the kind from the cell above on a push, from the cell below on a pop.
// ----------------------------------------------------------------------------
module bbc_cell
  import bbc_pkg::*;
(
  input  logic      clk,
  input  stack_op_t op,
  input  kind_t     kind_above,
  input  kind_t     kind_below,
  output kind_t     kind_q
);

  kind_t kind_r;
  kind_t kind_nxt;

  always_comb begin
    priority if (op.push) begin
      kind_nxt = kind_above;
    end else if (op.pop) begin
      kind_nxt = kind_below;
    end else begin
      kind_nxt = kind_r;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_q = kind_r;

endmodule
